// ----- sv/rav_pkg.sv -----
// ----------------------------------------------------------------------------
// rav_pkg
// Types and constants shared by the rank-by-value cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rav_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_t;

  // An item moving down the chain looking for its slot.
  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] value;
    logic        [RANK_W-1:0]  cnt;
  } travel_t;

  // Per-cell occupancy and rank, shifted toward cell zero when draining.
  typedef struct packed {
    logic              vld;
    logic [RANK_W-1:0] rank;
  } held_t;

endpackage

`default_nettype wire

// ----- sv/rav_cell.sv -----
// ----------------------------------------------------------------------------
// rav_cell
// One slot of the ranking chain: holds a value and its running rank.
// ----------------------------------------------------------------------------
`default_nettype none

module rav_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rav_pkg::travel_t trav_i,
  output rav_pkg::travel_t      trav_o,
  input  wire logic             shift_en,
  input  wire rav_pkg::held_t   held_i,
  output rav_pkg::held_t        held_o
);
  import rav_pkg::*;

  held_t                     held_r;
  held_t                     held_nxt;
  travel_t                   trav_r;
  travel_t                   trav_nxt;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  logic                      le;

  always_comb begin
    le        = held_r.vld && (value_r <= trav_i.value);
    held_nxt  = held_r;
    value_nxt = value_r;
    trav_nxt  = '0;
    if (shift_en) begin
      held_nxt = held_i;
    end else if (trav_i.vld) begin
      if (held_r.vld) begin
        if (!le) begin
          held_nxt.rank = held_r.rank + RANK_W'(1);
        end
        trav_nxt.vld   = 1'b1;
        trav_nxt.value = trav_i.value;
        trav_nxt.cnt   = trav_i.cnt + RANK_W'(le);
      end else begin
        held_nxt.vld  = 1'b1;
        held_nxt.rank = trav_i.cnt;
        value_nxt     = trav_i.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.vld <= 1'b0;
      trav_r.vld <= 1'b0;
    end else begin
      held_r.vld <= held_nxt.vld;
      trav_r.vld <= trav_nxt.vld;
    end
    held_r.rank  <= held_nxt.rank;
    trav_r.value <= trav_nxt.value;
    trav_r.cnt   <= trav_nxt.cnt;
    value_r      <= value_nxt;
  end

  assign trav_o = trav_r;
  assign held_o = held_r;

endmodule

`default_nettype wire

// ----- sv/rank_assign_by_value.sv -----
// ----------------------------------------------------------------------------
// rank_assign_by_value
// Ranks a run of signed values and returns each rank in load order.
// ----------------------------------------------------------------------------
// Values are taken one item per cycle while a run loads. Each value enters a
// chain of MAX_ITEMS cells and moves one cell per cycle until it reaches the
// first free cell, counting held values that are less than or equal to it,
// while every held value greater than it moves up one rank. Ties rank by
// load position. After the item flagged last, input stalls until the chain has
// settled, then the ranks shift out of cell zero at one item per cycle under
// back-pressure, the final one marked by out_tlast. Values beyond MAX_ITEMS
// are dropped and out_tuser is set on every result of that run. A new run may
// load while the final result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_assign_by_value #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // rank[5:0], zero[7:6]
  output logic             out_tuser,  // overflow
  output logic             out_tlast
);
  import rav_pkg::*;

  localparam int FILL_W = $clog2(MAX_ITEMS + 1);

  state_t             state_r;
  state_t             state_nxt;
  logic [FILL_W-1:0]  fill_r;
  logic               dropped_r;
  logic               out_valid_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic               out_ovf_r;
  logic               out_last_r;
  logic               in_acc;
  logic               room;
  logic               load_out;
  logic               busy;
  travel_t            trav [0:MAX_ITEMS];
  held_t              held [0:MAX_ITEMS];

  assign in_acc = in_tvalid && in_tready;
  assign room   = fill_r < FILL_W'(MAX_ITEMS);

  assign trav[0].vld   = in_acc && room;
  assign trav[0].value = $signed(in_tdata);
  assign trav[0].cnt   = '0;

  assign held[MAX_ITEMS] = '0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    rav_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .trav_i   (trav[g]),
      .trav_o   (trav[g+1]),
      .shift_en (load_out),
      .held_i   (held[g+1]),
      .held_o   (held[g])
    );
  end

  always_comb begin
    busy = 1'b0;
    for (int i = 1; i <= MAX_ITEMS; i++) begin
      busy = busy | trav[i].vld;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) state_nxt = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (!busy) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (load_out && fill_r == FILL_W'(1)) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_LOAD);
    load_out  = (state_r == ST_DRAIN) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (room) begin
          fill_r <= fill_r + FILL_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end else if (load_out) begin
        fill_r <= fill_r - FILL_W'(1);
        if (fill_r == FILL_W'(1)) dropped_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load_out) begin
      out_rank_r <= held[0].rank;
      out_ovf_r  <= dropped_r;
      out_last_r <= (fill_r == FILL_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rank_r};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- tb/rank_assign_by_value_tb.sv -----
// ----------------------------------------------------------------------------
// rank_assign_by_value_tb
// Self-checking testbench for the rank-by-value cell chain.
// ----------------------------------------------------------------------------
// Runs of signed values are streamed in, and each run ends with an item that
// has in_tlast set. A behavioral ranker computes the expected ranks in load
// order, with the overflow flag and the end-of-run mark. Every result is
// compared against the oldest pending expectation. Directed runs cover the
// value extremes, ties, single-item runs, a full store and dropped items.
// Random runs follow, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_assign_by_value_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rav_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 16;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 2000;

  typedef enum int {
    MIX_FULL,
    MIX_NARROW,
    MIX_EDGE
  } value_mix_t;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic              overflow;
    logic              last_rank;
  } rank_result_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               out_tuser;
  logic               out_tlast;

  logic signed [VALUE_W-1:0] held_value [CAPACITY];
  logic        [RANK_W-1:0]  held_rank  [CAPACITY];
  int                        held_count = 0;
  logic                      run_dropped = 1'b0;
  rank_result_t              pending_ranks [$];

  int mismatches  = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int quiet_count = 0;
  int ready_mode  = 0;
  int ready_span  = 0;

  rank_assign_by_value #(
    .MAX_ITEMS(CAPACITY)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void rank_arrival(input logic signed [VALUE_W-1:0] v,
                                       input logic lst);
    int           below;
    rank_result_t r;
    if (held_count < CAPACITY) begin
      below = 0;
      for (int i = 0; i < held_count; i++) begin
        if (held_value[i] > v) begin
          held_rank[i] = held_rank[i] + 1'b1;
        end else begin
          below++;
        end
      end
      held_value[held_count] = v;
      held_rank[held_count]  = below[RANK_W-1:0];
      held_count++;
    end else begin
      run_dropped = 1'b1;
    end
    if (lst) begin
      for (int i = 0; i < held_count; i++) begin
        r.rank      = held_rank[i];
        r.overflow  = run_dropped;
        r.last_rank = (i == held_count - 1);
        pending_ranks.push_back(r);
      end
      held_count  = 0;
      run_dropped = 1'b0;
      for (int i = 0; i < CAPACITY; i++) held_rank[i] = '0;
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value(input value_mix_t mix);
    int signed s;
    case (mix)
      MIX_NARROW: begin
        s = int'($urandom_range(0, 6)) - 3;
        return s;
      end
      MIX_EDGE: begin
        case ($urandom_range(0, 6))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh8000_0001;
          3: return 32'sh7fff_fffe;
          4: return 0;
          5: return -1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic lst);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rank_arrival(v, lst);
    items_sent++;
  endtask

  task automatic send_run(input int len, input value_mix_t mix);
    for (int i = 0; i < len; i++) send_item(pick_value(mix), i == len - 1);
  endtask

  task automatic test_extremes();
    send_item(32'sh0000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sh0000_0001, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shaaaa_aaaa, 1'b0);
    send_item(32'sh8000_0001, 1'b0);
    send_item(32'sh7fff_fffe, 1'b0);
    send_item(32'sh0000_0000, 1'b1);
  endtask

  task automatic test_single_item_runs();
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7fff_ffff, 1'b1);
  endtask

  task automatic test_ties_and_descending();
    for (int i = 0; i < 6; i++) send_item(32'sh1234_5678, i == 5);
    for (int i = 5; i > 0; i--) send_item(i, i == 1);
  endtask

  task automatic test_store_full();
    send_run(CAPACITY, MIX_NARROW);
    send_run(CAPACITY + 3, MIX_FULL);
    send_run(3, MIX_EDGE);
  endtask

  task automatic test_random_runs();
    int         first;
    int         len;
    int         pick;
    value_mix_t mix;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 17) len = $urandom_range(1, 12);
      else if (pick < 19) len = $urandom_range(13, 40);
      else len = $urandom_range(60, 70);
      if (len > RANDOM_ITEMS - (items_sent - first)) begin
        len = RANDOM_ITEMS - (items_sent - first);
      end
      mix = value_mix_t'($urandom_range(0, 2));
      send_run(len, mix);
    end
  endtask

  always @(negedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_span <= $urandom_range(16, 96);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0) ? ~out_tready : out_tready;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_ranks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: rank %0d overflow %0b last %0b",
                   out_tdata[RANK_W-1:0], out_tuser, out_tlast);
        end
      end else begin
        if (out_tdata !== {2'b00, pending_ranks[0].rank} ||
            out_tuser !== pending_ranks[0].overflow ||
            out_tlast !== pending_ranks[0].last_rank) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"result mismatch: expected data %h overflow %0b last %0b, ",
                      "got data %h overflow %0b last %0b"},
                     {2'b00, pending_ranks[0].rank}, pending_ranks[0].overflow,
                     pending_ranks[0].last_rank, out_tdata, out_tuser, out_tlast);
          end
        end
        void'(pending_ranks.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= STALL_LIMIT) begin
      $display("rank_assign_by_value_tb NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) held_rank[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_single_item_runs();
    test_ties_and_descending();
    test_store_full();
    test_random_runs();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("rank_assign_by_value_tb OK");
    end else begin
      $display("rank_assign_by_value_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
sv/rav_pkg.sv
sv/rav_cell.sv
sv/rank_assign_by_value.sv
tb/rank_assign_by_value_tb.sv
